@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Condition in a cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ hw/rtl/wsd_pkg.sv @@
`timescale 1ns / 1ps
package wsd_pkg;

   // Sample and result field width (Q8.8).
   localparam int SAMPLE_W = 16;
   // Default ring length.
   localparam int DEFAULT_WINDOW = 32;
   // Threshold after reset: 0.25 in Q8.8.
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd64;
   // Operand width of the shared multiplier.
   localparam int MUL_W = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_CALC,
      ST_START,
      ST_ROOT,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      RT_IDLE,
      RT_SQRT,
      RT_DIV
   } root_state_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_LL,
      MUL_LH,
      MUL_HH
   } mul_op_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_S2,
      DST_LL,
      DST_LH,
      DST_HH
   } prod_dst_type;

   // Sequencer commands to the arithmetic datapath.
   typedef struct packed {
      logic       clear;
      logic       acc;
      mul_op_type mul_op;
      logic       diff;
   } arith_ctl_type;

endpackage

@@ hw/rtl/window_std_deviation_steady_detect.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Payload
// req_      in         tdata[15:0] speed_sample; tuser[0] stopped
// rsp_      out        tdata[15:0] deviation; tuser[0] result_valid, tuser[1] steady
// csr_      in         csr_wr_data[15:0] steady_threshold, written when csr_wr_en
//
// A request that yields a valid deviation takes these steps: one store read per cycle
// through the shared multiplier, then the squared-sum partial products in it,
// one root digit per cycle in the trial subtractor, then one reciprocal multiply.
// Other requests go straight to the output register.
// Reset is synchronous; the ring contents are kept, index and fill flag are cleared.
// A result waits in the output register; the next request is taken meanwhile.
module window_std_deviation_steady_detect #(
   parameter int WINDOW_LENGTH = wsd_pkg::DEFAULT_WINDOW
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [wsd_pkg::SAMPLE_W-1:0] req_tdata,   // [15:0] speed_sample
   input  logic [0:0]                   req_tuser,   // [0] stopped
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [wsd_pkg::SAMPLE_W-1:0] rsp_tdata,   // [15:0] deviation
   output logic [1:0]                   rsp_tuser,   // [0] result_valid, [1] steady
   input  logic                         csr_wr_en,
   input  logic [wsd_pkg::SAMPLE_W-1:0] csr_wr_data
);
   import wsd_pkg::*;

   localparam int AW = $clog2(WINDOW_LENGTH);
   localparam int DW = 2 * (SAMPLE_W + AW);

   arith_ctl_type       arith_ctl;
   logic                st_wr_en;
   logic [AW-1:0]       st_wr_addr;
   logic                st_rd_en;
   logic [AW-1:0]       st_rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic [DW-1:0]       d_val;
   logic                root_start;
   logic                root_done;
   logic [SAMPLE_W-1:0] quot;
   logic                out_load;
   logic                out_valid;
   logic [SAMPLE_W-1:0] thr_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_dev_ff;
   logic [1:0]          rsp_flag_ff;
   logic [SAMPLE_W-1:0] dev_in;

   wsd_ctrl #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .AW           (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_stopped(req_tuser[0]),
      .req_ready  (req_tready),
      .st_wr_en   (st_wr_en),
      .st_wr_addr (st_wr_addr),
      .st_rd_en   (st_rd_en),
      .st_rd_addr (st_rd_addr),
      .arith_ctl  (arith_ctl),
      .root_start (root_start),
      .root_done  (root_done),
      .rsp_full   (rsp_valid_ff),
      .rsp_ready  (rsp_tready),
      .out_load   (out_load),
      .out_valid  (out_valid)
   );

   wsd_store #(
      .DEPTH(WINDOW_LENGTH),
      .AW   (AW)
   ) u_store (
      .clock  (clock),
      .wr_en  (st_wr_en),
      .wr_addr(st_wr_addr),
      .wr_data(req_tdata),
      .rd_en  (st_rd_en),
      .rd_addr(st_rd_addr),
      .rd_data(rd_data)
   );

   wsd_arith #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .DW           (DW)
   ) u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (arith_ctl),
      .rd_data(rd_data),
      .d_out  (d_val)
   );

   wsd_root #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .DW           (DW)
   ) u_root (
      .clock(clock),
      .reset(reset),
      .start(root_start),
      .d_in (d_val),
      .done (root_done),
      .quot (quot)
   );

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // Drop the deviation for a suppressed result.
   assign dev_in = out_valid ? quot : '0;

   // Output register: load a finished result, hold it until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_dev_ff  <= dev_in;
         rsp_flag_ff <= {out_valid && (dev_in < thr_ff), out_valid};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_dev_ff;
   assign rsp_tuser  = rsp_flag_ff;

endmodule

@@ hw/rtl/wsd_store.sv @@
`timescale 1ns / 1ps
module wsd_store #(
   parameter int DEPTH = wsd_pkg::DEFAULT_WINDOW,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [wsd_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [wsd_pkg::SAMPLE_W-1:0] rd_data
);
   import wsd_pkg::*;

   logic [SAMPLE_W-1:0] mem_ff [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // Write the new sample, register the read word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/wsd_arith.sv @@
`timescale 1ns / 1ps
module wsd_arith #(
   parameter int WINDOW_LENGTH = wsd_pkg::DEFAULT_WINDOW,
   parameter int DW            = 2 * (wsd_pkg::SAMPLE_W + $clog2(WINDOW_LENGTH))
) (
   input  logic                         clock,
   input  logic                         reset,
   input  wsd_pkg::arith_ctl_type       ctl,
   input  logic [wsd_pkg::SAMPLE_W-1:0] rd_data,
   output logic [DW-1:0]                d_out
);
   import wsd_pkg::*;

   localparam int IW   = $clog2(WINDOW_LENGTH);
   localparam int S1W  = SAMPLE_W + IW;
   localparam int S2W  = 2 * SAMPLE_W + IW;
   localparam int HALF = (S1W + 1) / 2;
   localparam int HIW  = S1W - HALF;
   localparam int PW   = 2 * MUL_W;
   localparam logic [DW-1:0] W_D = DW'(WINDOW_LENGTH);

   logic [S1W-1:0]   s1_ff;
   logic [S2W-1:0]   s2_ff;
   logic [DW-1:0]    sq_ff;
   logic [DW-1:0]    d_ff;
   logic [PW-1:0]    prod_ff;
   logic [PW-1:0]    prod_in;
   prod_dst_type     dst_ff;
   prod_dst_type     dst_in;
   logic [MUL_W-1:0] mul_a;
   logic [MUL_W-1:0] mul_b;
   logic [HALF-1:0]  s1_lo;
   logic [HIW-1:0]   s1_hi;
   logic [DW-1:0]    prod_ext;
   logic [DW-1:0]    d_in;

   assign s1_lo    = s1_ff[HALF-1:0];
   assign s1_hi    = s1_ff[S1W-1:HALF];
   assign prod_ext = DW'(prod_ff);

   // Pick the multiplier operands: sample squares during the sweep,
   // then the partial products of the squared sum.
   always_comb begin
      case (ctl.mul_op)
         MUL_LL: begin
            mul_a  = MUL_W'(s1_lo);
            mul_b  = MUL_W'(s1_lo);
            dst_in = DST_LL;
         end
         MUL_LH: begin
            mul_a  = MUL_W'(s1_lo);
            mul_b  = MUL_W'(s1_hi);
            dst_in = DST_LH;
         end
         MUL_HH: begin
            mul_a  = MUL_W'(s1_hi);
            mul_b  = MUL_W'(s1_hi);
            dst_in = DST_HH;
         end
         default: begin
            mul_a  = MUL_W'(rd_data);
            mul_b  = MUL_W'(rd_data);
            dst_in = ctl.acc ? DST_S2 : DST_NONE;
         end
      endcase
   end

   assign prod_in = PW'(mul_a) * PW'(mul_b);

   // Scale the sum of squares by the window length (constant) and subtract.
   assign d_in = (DW'(s2_ff) * W_D) - sq_ff;

   // Tag of the registered product.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         dst_ff <= DST_NONE;
      end else begin
         dst_ff <= dst_in;
      end
   end

   // Accumulate sums; fold the registered product into its destination.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctl.clear) begin
         s1_ff <= '0;
         s2_ff <= '0;
         sq_ff <= '0;
      end else begin
         if (ctl.acc) begin
            s1_ff <= s1_ff + S1W'(rd_data);
         end
         case (dst_ff)
            DST_S2: s2_ff <= s2_ff + S2W'(prod_ff);
            DST_LL: sq_ff <= sq_ff + prod_ext;
            DST_LH: sq_ff <= sq_ff + (prod_ext << (HALF + 1));
            DST_HH: sq_ff <= sq_ff + (prod_ext << (2 * HALF));
            default: begin
            end
         endcase
      end
      if (ctl.diff) begin
         d_ff <= d_in;
      end
   end

   assign d_out = d_ff;

endmodule

@@ hw/rtl/wsd_root.sv @@
`timescale 1ns / 1ps
module wsd_root #(
   parameter int WINDOW_LENGTH = wsd_pkg::DEFAULT_WINDOW,
   parameter int DW            = 2 * (wsd_pkg::SAMPLE_W + $clog2(WINDOW_LENGTH))
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DW-1:0]                d_in,
   output logic                         done,
   output logic [wsd_pkg::SAMPLE_W-1:0] quot
);
   import wsd_pkg::*;

   localparam int IW   = $clog2(WINDOW_LENGTH);
   localparam int RW   = DW / 2;
   localparam int RMW  = RW + 2;
   localparam int SUBW = RMW + 2;
   localparam int CW   = $clog2(RW);
   localparam int RCW  = RW + 1;
   localparam int SH   = RW + IW;
   localparam int PRW  = RW + RCW;
   localparam logic [CW-1:0] STEP_LAST = CW'(RW - 1);
   // Window length reciprocal, rounded up and scaled by 2^SH; exact for any RW-bit root.
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SH) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
   localparam logic [RCW-1:0] RECIP = RCW'(RECIP_WIDE);

   root_state_type state_ff;
   root_state_type state_in;
   logic [CW-1:0]  cnt_ff;
   logic [DW-1:0]  rad_ff;
   logic [RMW-1:0] rem_ff;
   logic [RW-1:0]  root_ff;
   logic           done_ff;
   logic [SAMPLE_W-1:0] quot_ff;
   logic [SUBW-1:0] op_a;
   logic [SUBW-1:0] op_b;
   logic [SUBW-1:0] diff;
   logic [PRW-1:0] scaled;
   logic           fits;
   logic           div_phase;
   logic           stepping;
   logic           last_step;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RT_IDLE: begin
            if (start) begin
               state_in = RT_SQRT;
            end
         end
         RT_SQRT: begin
            if (last_step) begin
               state_in = RT_DIV;
            end
         end
         RT_DIV: state_in = RT_IDLE;
         default: state_in = RT_IDLE;
      endcase
   end

   // Phase decode.
   always_comb begin
      div_phase = (state_ff == RT_DIV);
      stepping  = (state_ff == RT_SQRT);
      last_step = stepping && (cnt_ff == STEP_LAST);
   end

   // Trial subtractor: one root digit per step.
   always_comb begin
      op_a = {rem_ff, rad_ff[DW-1 -: 2]};
      op_b = SUBW'({root_ff, 2'b01});
      diff = op_a - op_b;
      fits = (op_a >= op_b);
   end

   // Divide the root by the window length through the constant reciprocal.
   assign scaled = PRW'(root_ff) * PRW'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RT_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= div_phase;
      end
   end

   // Load the radicand, then shift one digit per cycle.
   always_ff @(posedge clock) begin
      if (start && (state_ff == RT_IDLE)) begin
         rad_ff  <= d_in;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (stepping) begin
         rad_ff  <= rad_ff << 2;
         root_ff <= {root_ff[RW-2:0], fits};
         cnt_ff  <= last_step ? '0 : cnt_ff + 1'b1;
         rem_ff  <= fits ? diff[RMW-1:0] : op_a[RMW-1:0];
      end
      // Capture the scaled quotient once the root is complete.
      if (div_phase) begin
         quot_ff <= scaled[SH +: SAMPLE_W];
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ hw/rtl/wsd_ctrl.sv @@
`timescale 1ns / 1ps
module wsd_ctrl #(
   parameter int WINDOW_LENGTH = wsd_pkg::DEFAULT_WINDOW,
   parameter int AW            = $clog2(WINDOW_LENGTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stopped,
   output logic                   req_ready,
   output logic                   st_wr_en,
   output logic [AW-1:0]          st_wr_addr,
   output logic                   st_rd_en,
   output logic [AW-1:0]          st_rd_addr,
   output wsd_pkg::arith_ctl_type arith_ctl,
   output logic                   root_start,
   input  logic                   root_done,
   input  logic                   rsp_full,
   input  logic                   rsp_ready,
   output logic                   out_load,
   output logic                   out_valid
);
   import wsd_pkg::*;

   localparam logic [AW-1:0] IDX_LAST = AW'(WINDOW_LENGTH - 1);
   localparam logic [2:0] CALC_LL   = 3'd0;
   localparam logic [2:0] CALC_LH   = 3'd1;
   localparam logic [2:0] CALC_HH   = 3'd2;
   localparam logic [2:0] CALC_DIFF = 3'd4;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic [AW-1:0]  wr_idx_ff;
   logic           full_ff;
   logic [AW-1:0]  cnt_ff;
   logic [2:0]     step_ff;
   logic           valid_ff;
   logic           rd_pend_ff;
   logic           accept;
   logic           wr_last;
   logic           valid_now;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign wr_last   = (wr_idx_ff == IDX_LAST);
   assign valid_now = (full_ff || wr_last) && !req_stopped;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = valid_now ? ST_SWEEP : ST_OUT;
            end
         end
         ST_SWEEP: begin
            if (cnt_ff == IDX_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_CALC;
         ST_CALC: begin
            if (step_ff == CALC_DIFF) begin
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_ROOT;
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_full || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready        = (state_ff == ST_IDLE);
      st_wr_en         = accept;
      st_wr_addr       = wr_idx_ff;
      st_rd_en         = (state_ff == ST_SWEEP);
      st_rd_addr       = cnt_ff;
      arith_ctl.clear  = accept;
      arith_ctl.acc    = rd_pend_ff;
      arith_ctl.diff   = (state_ff == ST_CALC) && (step_ff == CALC_DIFF);
      arith_ctl.mul_op = MUL_NONE;
      if (state_ff == ST_CALC) begin
         case (step_ff)
            CALC_LL: arith_ctl.mul_op = MUL_LL;
            CALC_LH: arith_ctl.mul_op = MUL_LH;
            CALC_HH: arith_ctl.mul_op = MUL_HH;
            default: arith_ctl.mul_op = MUL_NONE;
         endcase
      end
      root_start = (state_ff == ST_START);
      out_load   = (state_ff == ST_OUT) && (!rsp_full || rsp_ready);
      out_valid  = valid_ff;
   end

   // Control registers: ring index, fill flag, read pipeline tag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wr_idx_ff  <= '0;
         full_ff    <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == ST_SWEEP);
         if (accept) begin
            wr_idx_ff <= wr_last ? '0 : wr_idx_ff + 1'b1;
            full_ff   <= full_ff || wr_last;
         end
      end
   end

   // Sweep address and calculation step counters.
   always_ff @(posedge clock) begin
      if (accept) begin
         cnt_ff   <= '0;
         valid_ff <= valid_now;
      end else if (state_ff == ST_SWEEP) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (state_ff == ST_DRAIN) begin
         step_ff <= '0;
      end else if (state_ff == ST_CALC) begin
         step_ff <= step_ff + 1'b1;
      end
   end

endmodule

@@ hw/rtl/wsd_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [wsd_pkg::SAMPLE_W-1:0] rsp_tdata,
   input logic [1:0]                   rsp_tuser
);
   import wsd_pkg::*;

   // Steady is only reported on a valid deviation.
   `ASSERT_IMPLY(a_steady_needs_valid, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0])

   // A suppressed result carries a zero deviation.
   `ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0)

   // The block is busy right after taking a request.
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // A stalled result holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind window_std_deviation_steady_detect wsd_checker u_wsd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
